/* rtl/core/cdeq_pkg.sv */
// Shared types and constants for the circular double-ended queue.
// Holds store geometry, operation and status codes, controller states and commands.
// Depends on nothing; every other file of the block imports it.
`default_nettype none

package cdeq_pkg;

    localparam int DEPTH = 128;
    localparam int PTR_W = $clog2(DEPTH);
    localparam int EFF_W = PTR_W + 1;
    localparam int CAP_W = 8;
    localparam int DATA_W = 32;
    localparam int OP_W = 3;
    localparam int STAT_W = 2;
    localparam int IN_W = 40;
    localparam int OUT_W = 72;

    localparam logic [OP_W-1:0] OP_NONE       = 3'd0;
    localparam logic [OP_W-1:0] OP_PUSH_FRONT = 3'd1;
    localparam logic [OP_W-1:0] OP_PUSH_REAR  = 3'd2;
    localparam logic [OP_W-1:0] OP_POP_FRONT  = 3'd3;
    localparam logic [OP_W-1:0] OP_POP_REAR   = 3'd4;

    localparam logic [STAT_W-1:0] STAT_OK        = 2'd0;
    localparam logic [STAT_W-1:0] STAT_OVERFLOW  = 2'd1;
    localparam logic [STAT_W-1:0] STAT_UNDERFLOW = 2'd2;

    localparam logic [CAP_W-1:0] CAP_RESET = 8'd128;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_READ,
        ST_LOAD
    } state_t;

    typedef struct packed {
        logic capture;
        logic exec;
        logic read;
        logic load;
    } cmd_t;

endpackage

`default_nettype wire

/* rtl/core/cdeq_ctrl.sv */
// Controller state machine of the circular double-ended queue.
// Sequences capture, update, store read and result load; owns both handshakes.
// Depends on cdeq_pkg.
`default_nettype none

module cdeq_ctrl
    import cdeq_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic s_tvalid,
    output logic      s_tready,
    output logic      m_tvalid,
    input  wire logic m_tready,
    output cmd_t      cmd
);

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                state_next = ST_READ;
            end
            ST_READ:
            begin
                state_next = ST_LOAD;
            end
            ST_LOAD:
            begin
                if (!out_valid_reg || m_tready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        s_tready    = 1'b0;
        cmd.capture = 1'b0;
        cmd.exec    = 1'b0;
        cmd.read    = 1'b0;
        cmd.load    = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                s_tready    = 1'b1;
                cmd.capture = s_tvalid;
            end
            ST_EXEC:
            begin
                cmd.exec = 1'b1;
            end
            ST_READ:
            begin
                cmd.read = 1'b1;
            end
            ST_LOAD:
            begin
                cmd.load = !out_valid_reg || m_tready;
            end
            default:
            begin
                s_tready = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.load)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign m_tvalid = out_valid_reg;

`ifndef SYNTHESIS
    a_accept_to_exec: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> (state_reg == ST_EXEC))
        else $error("accepted transfer did not start the update");

    a_exec_to_read: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_EXEC) |=> (state_reg == ST_READ))
        else $error("update was not followed by the store read");

    a_load_sets_valid: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load |=> (m_tvalid && state_reg == ST_IDLE))
        else $error("loaded result is not offered");
`endif

endmodule

`default_nettype wire

/* rtl/core/cdeq_datapath.sv */
// Datapath of the circular double-ended queue: item register, head and tail
// pointers, element store with two registered read ports, and result register.
// Depends on cdeq_pkg; driven by cdeq_ctrl commands.
`default_nettype none

module cdeq_datapath
    import cdeq_pkg::*;
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire cmd_t                cmd,
    input  wire logic [CAP_W-1:0]    capacity,
    input  wire logic [OP_W-1:0]     op,
    input  wire logic [DATA_W-1:0]   value,
    output logic      [DATA_W-1:0]   front_value,
    output logic      [DATA_W-1:0]   rear_value,
    output logic                     ends_valid,
    output logic                     is_empty,
    output logic                     is_full,
    output logic      [STAT_W-1:0]   status
);

    function automatic logic [EFF_W-1:0] eff_cap(input logic [CAP_W-1:0] c);
        logic [31:0] c32;
        c32 = 32'(c);
        if (c32 == 32'd0)
        begin
            return EFF_W'(1);
        end
        if (c32 > 32'(DEPTH))
        begin
            return EFF_W'(DEPTH);
        end
        return EFF_W'(c32);
    endfunction

    function automatic logic [PTR_W-1:0] ptr_next(input logic [PTR_W-1:0] p,
                                                  input logic [EFF_W-1:0] c);
        logic [EFF_W-1:0] inc;
        inc = {1'b0, p} + EFF_W'(1);
        return (inc >= c) ? '0 : inc[PTR_W-1:0];
    endfunction

    function automatic logic [PTR_W-1:0] ptr_prev(input logic [PTR_W-1:0] p,
                                                  input logic [EFF_W-1:0] c);
        logic [EFF_W-1:0] dec;
        dec = c - EFF_W'(1);
        return (p == '0) ? dec[PTR_W-1:0] : p - PTR_W'(1);
    endfunction

    logic [DATA_W-1:0] mem [DEPTH];

    logic [OP_W-1:0]   op_reg;
    logic [DATA_W-1:0] value_reg;
    logic [PTR_W-1:0]  head_reg;
    logic [PTR_W-1:0]  head_next;
    logic [PTR_W-1:0]  tail_reg;
    logic [PTR_W-1:0]  tail_next;
    logic              empty_reg;
    logic              empty_next;
    logic [STAT_W-1:0] stat_reg;
    logic [STAT_W-1:0] stat_next;
    logic [DATA_W-1:0] rd_head_reg;
    logic [DATA_W-1:0] rd_tail_reg;
    logic [DATA_W-1:0] front_reg;
    logic [DATA_W-1:0] rear_reg;
    logic              ends_valid_reg;
    logic              is_empty_reg;
    logic              is_full_reg;
    logic [STAT_W-1:0] status_reg;

    logic [EFF_W-1:0]  cap_eff;
    logic              full_now;
    logic              wr_en;
    logic [PTR_W-1:0]  wr_addr;

    assign cap_eff  = eff_cap(capacity);
    assign full_now = !empty_reg && (ptr_next(tail_reg, cap_eff) == head_reg);

    always_comb
    begin
        head_next  = head_reg;
        tail_next  = tail_reg;
        empty_next = empty_reg;
        stat_next  = STAT_OK;
        wr_en      = 1'b0;
        wr_addr    = '0;
        case (op_reg)
            OP_PUSH_FRONT, OP_PUSH_REAR:
            begin
                if (full_now)
                begin
                    stat_next = STAT_OVERFLOW;
                end
                else if (empty_reg)
                begin
                    head_next  = '0;
                    tail_next  = '0;
                    empty_next = 1'b0;
                    wr_en      = 1'b1;
                    wr_addr    = '0;
                end
                else if (op_reg == OP_PUSH_FRONT)
                begin
                    head_next = ptr_prev(head_reg, cap_eff);
                    wr_en     = 1'b1;
                    wr_addr   = head_next;
                end
                else
                begin
                    tail_next = ptr_next(tail_reg, cap_eff);
                    wr_en     = 1'b1;
                    wr_addr   = tail_next;
                end
            end
            OP_POP_FRONT, OP_POP_REAR:
            begin
                if (empty_reg)
                begin
                    stat_next = STAT_UNDERFLOW;
                end
                else if (head_reg == tail_reg)
                begin
                    empty_next = 1'b1;
                    head_next  = '0;
                    tail_next  = '0;
                end
                else if (op_reg == OP_POP_FRONT)
                begin
                    head_next = ptr_next(head_reg, cap_eff);
                end
                else
                begin
                    tail_next = ptr_prev(tail_reg, cap_eff);
                end
            end
            default:
            begin
                stat_next = STAT_OK;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= '0;
            tail_reg  <= '0;
            empty_reg <= 1'b1;
        end
        else if (cmd.exec)
        begin
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            empty_reg <= empty_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            op_reg    <= op;
            value_reg <= value;
        end
        if (cmd.exec)
        begin
            stat_reg <= stat_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.exec && wr_en)
        begin
            mem[wr_addr] <= value_reg;
        end
        if (cmd.read)
        begin
            rd_head_reg <= mem[head_reg];
            rd_tail_reg <= mem[tail_reg];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            front_reg      <= empty_reg ? '0 : rd_head_reg;
            rear_reg       <= empty_reg ? '0 : rd_tail_reg;
            ends_valid_reg <= !empty_reg;
            is_empty_reg   <= empty_reg;
            is_full_reg    <= full_now;
            status_reg     <= stat_reg;
        end
    end

    assign front_value = front_reg;
    assign rear_value  = rear_reg;
    assign ends_valid  = ends_valid_reg;
    assign is_empty    = is_empty_reg;
    assign is_full     = is_full_reg;
    assign status      = status_reg;

endmodule

`default_nettype wire

/* rtl/core/circular_double_ended_queue.sv */
// Top level of the circular double-ended queue: stream ports, APB capacity
// register, and the controller and datapath instances.
// Depends on cdeq_pkg, cdeq_ctrl and cdeq_datapath.
`default_nettype none

// A deque of 32-bit words in a circular store of 128 entries, of which the
// capacity register selects how many are in use. Each accepted input transfer
// carries one operation and yields exactly one result transfer with the front
// and rear words, the empty and full flags and an overflow or underflow
// status. An item passes through capture, pointer update with store write,
// a registered read of the store at head and tail, and loading of the result
// register, in that order; the read follows the write, and a new item is
// accepted only after the result of the last one is loaded. A finished result
// waits in its own register, so the next item is accepted while it is still
// pending. The store needs no clearing after reset. Change capacity only while idle.

module circular_double_ended_queue
    import cdeq_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              s_tvalid,
    output logic                   s_tready,
    input  wire logic [IN_W-1:0]   s_tdata,   // op[2:0], value[34:3], zeros
    output logic                   m_tvalid,
    input  wire logic              m_tready,
    output logic      [OUT_W-1:0]  m_tdata,   // front_value[31:0], rear_value[63:32],
                                              // ends_valid[64], is_empty[65],
                                              // is_full[66], status[68:67], zeros
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [2:0]        paddr,
    input  wire logic [31:0]       pwdata,
    output logic      [31:0]       prdata,
    output logic                   pready
);

    localparam logic [2:0] ADDR_CAPACITY = 3'd0;

    logic [CAP_W-1:0]  capacity_reg;
    cmd_t              cmd;
    logic [DATA_W-1:0] front_value;
    logic [DATA_W-1:0] rear_value;
    logic              ends_valid;
    logic              is_empty;
    logic              is_full;
    logic [STAT_W-1:0] status;

    assign pready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            capacity_reg <= CAP_RESET;
        end
        else if (psel && penable && pwrite && pready && paddr == ADDR_CAPACITY)
        begin
            capacity_reg <= pwdata[CAP_W-1:0];
        end
    end

    assign prdata = (paddr == ADDR_CAPACITY) ? 32'(capacity_reg) : '0;

    cdeq_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd)
    );

    cdeq_datapath u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .capacity    (capacity_reg),
        .op          (s_tdata[OP_W-1:0]),
        .value       (s_tdata[OP_W+DATA_W-1:OP_W]),
        .front_value (front_value),
        .rear_value  (rear_value),
        .ends_valid  (ends_valid),
        .is_empty    (is_empty),
        .is_full     (is_full),
        .status      (status)
    );

    assign m_tdata = {3'b000, status, is_full, is_empty, ends_valid, rear_value, front_value};

endmodule

`default_nettype wire
